>>> rtl/polygon_rect_overlap_macros.svh
// Assertion macros shared by the checker of polygon_rect_overlap.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef POLYGON_RECT_OVERLAP_MACROS_SVH
`define POLYGON_RECT_OVERLAP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pro_pkg.sv
// Shared types and constants for the polygon/rectangle overlap block.
// No dependencies.
package pro_pkg;

	localparam int MAX_VERTICES = 64;
	// Vertex counter holds 0..MAX_VERTICES.
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	// World coordinate: Q15.8 vertex plus Q15.8 tile offset.
	localparam int W_W = 25;
	// Rectangle corner in Q.8: (16-bit + 15-bit) pixels shifted by eight.
	localparam int C_W = 26;
	// Coordinate sums never wrap for any vertex count.
	localparam int SUM_W = W_W + CNT_W;
	// Multiplier operand and product widths.
	localparam int OP_W = 27;
	localparam int PROD_W = 2 * OP_W;
	// Decoupling queue.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);
	// Step counter: four corner or bound steps plus one drain step.
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_LAST = 3'd3;
	localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd4;

	// One classified word passed from the front to the back.
	typedef struct packed {
		logic signed [W_W-1:0] wx;
		logic signed [W_W-1:0] wy;
		logic signed [C_W-1:0] left;
		logic signed [C_W-1:0] top;
		logic signed [C_W-1:0] right;
		logic signed [C_W-1:0] bottom;
		logic add;
		logic first;
		logic last;
	} entry_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_EDGE,
		B_CLOSE,
		B_CENT,
		B_EMIT
	} back_state_t;

	typedef enum logic [2:0] {
		CMP_NONE,
		CMP_CROSS_POS,
		CMP_CROSS_NEG,
		CMP_GE,
		CMP_LE
	} cmp_mode_t;

endpackage

>>> rtl/polygon_rect_overlap.sv
// Polygon/rectangle overlap test. Each input word is one polygon vertex with
// its tile offset and the query rectangle; the word marked last closes the
// polygon and yields one collides word. The front end takes a word per cycle,
// unless in_stall is high, into a four-word queue. The back end pops each
// vertex; for an added vertex other than the first it runs four corner tests
// through one shared multiply-compare unit and a drain step. A last vertex
// then adds the closing edge, the centroid bounds through the same unit, and
// the load of the result. After a result is taken the output does not offer
// a new one back to back.
module polygon_rect_overlap (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] vertex_x,
	input  logic [23:0] vertex_y,
	input  logic [23:0] tile_x,
	input  logic [23:0] tile_y,
	input  logic [15:0] rect_x,
	input  logic [15:0] rect_y,
	input  logic [14:0] rect_w,
	input  logic [14:0] rect_h,
	input  logic        last_vertex,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        collides
);
	import pro_pkg::*;

	logic   push;
	entry_t push_entry;
	logic   q_full;
	logic   q_valid;
	logic   pop;
	entry_t head;

	assign in_stall = q_full;

	// Front end.
	pro_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.q_full     (q_full),
		.vertex_x   (vertex_x),
		.vertex_y   (vertex_y),
		.tile_x     (tile_x),
		.tile_y     (tile_y),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.last_vertex(last_vertex),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decoupling queue.
	pro_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (head)
	);

	// Back end.
	pro_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.collides (collides)
	);

endmodule

>>> rtl/pro_front.sv
// Front end: accepts input words, forms world coordinates and rectangle corners,
// and tags each vertex as added, first and last. Depends on pro_pkg.
module pro_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   q_full,
	input  logic [23:0]            vertex_x,
	input  logic [23:0]            vertex_y,
	input  logic [23:0]            tile_x,
	input  logic [23:0]            tile_y,
	input  logic [15:0]            rect_x,
	input  logic [15:0]            rect_y,
	input  logic [14:0]            rect_w,
	input  logic [14:0]            rect_h,
	input  logic                   last_vertex,
	output logic                   push,
	output pro_pkg::entry_t        push_entry
);
	import pro_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [16:0]      rx_end;
	logic [16:0]      ry_end;

	assign push = in_valid && !q_full;

	// World position and rectangle corners in Q.8.
	always_comb begin
		rx_end = {rect_x[15], rect_x} + {2'b00, rect_w};
		ry_end = {rect_y[15], rect_y} + {2'b00, rect_h};
		push_entry.wx     = {vertex_x[23], vertex_x} + {tile_x[23], tile_x};
		push_entry.wy     = {vertex_y[23], vertex_y} + {tile_y[23], tile_y};
		push_entry.left   = {{2{rect_x[15]}}, rect_x, 8'h00};
		push_entry.top    = {{2{rect_y[15]}}, rect_y, 8'h00};
		push_entry.right  = {rx_end[16], rx_end, 8'h00};
		push_entry.bottom = {ry_end[16], ry_end, 8'h00};
		push_entry.add    = cnt_q < CNT_W'(MAX_VERTICES);
		push_entry.first  = cnt_q == '0;
		push_entry.last   = last_vertex;
	end

	// Local vertex count; a last vertex starts a new polygon.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			if (last_vertex) begin
				cnt_q <= '0;
			end else if (push_entry.add) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

>>> rtl/pro_queue.sv
// Short queue of classified words between the front and the back.
// Depends on pro_pkg.
module pro_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pro_pkg::entry_t push_entry,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output pro_pkg::entry_t head
);
	import pro_pkg::*;

	entry_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;

	assign full      = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

endmodule

>>> rtl/pro_back.sv
// Back end: runs the edge crossing tests and the centroid test on one shared
// multiply-compare unit and holds the result word. Depends on pro_pkg.
module pro_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  pro_pkg::entry_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            collides
);
	import pro_pkg::*;

	back_state_t            state_q;
	back_state_t            state_nx;
	logic [STEP_W-1:0]      k_q;
	entry_t                 e_q;
	logic signed [W_W-1:0]  prev_x_q, prev_y_q, first_x_q, first_y_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [3:0]             parity_q;
	logic                   inbox_q;
	logic                   out_valid_q;
	logic                   collides_q;

	// Multiply stage registers.
	logic signed [PROD_W-1:0] lhs_s1, rhs_s1;
	cmp_mode_t                mode_s1;
	logic [1:0]               k_s1;

	// FSM outputs.
	logic issue;
	logic step_end;
	logic emit;

	// Operand selection.
	logic signed [C_W-1:0]  px, py;
	logic signed [C_W-1:0]  xi, yi, xj, yj;
	logic signed [C_W-1:0]  d;
	logic signed [OP_W-1:0] dxp, dyp, dxj, bound, n_op;
	logic signed [PROD_W-1:0] p_lhs, p_rhs;
	logic signed [PROD_W-1:0] lhs_nx;
	logic                   straddle;
	cmp_mode_t              mode_nx;

	assign out_valid = out_valid_q;
	assign collides  = collides_q;

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					if (head.add && !head.first) begin
						state_nx = B_EDGE;
					end else if (head.last) begin
						state_nx = B_CLOSE;
					end
				end
			end
			B_EDGE: begin
				if (k_q == STEP_DRAIN) begin
					state_nx = e_q.last ? B_CLOSE : B_IDLE;
				end
			end
			B_CLOSE: begin
				if (k_q == STEP_DRAIN) begin
					state_nx = B_CENT;
				end
			end
			B_CENT: begin
				if (k_q == STEP_DRAIN) begin
					state_nx = B_EMIT;
				end
			end
			B_EMIT: begin
				if (!out_valid_q) begin
					state_nx = B_IDLE;
				end
			end
			default: state_nx = B_IDLE;
		endcase
	end

	// FSM outputs.
	always_comb begin
		pop      = 1'b0;
		issue    = 1'b0;
		step_end = 1'b0;
		emit     = 1'b0;
		case (state_q)
			B_IDLE: pop = q_valid;
			B_EDGE, B_CLOSE, B_CENT: begin
				issue    = k_q <= STEP_LAST;
				step_end = k_q == STEP_DRAIN;
			end
			B_EMIT: emit = !out_valid_q;
			default: pop = 1'b0;
		endcase
	end

	// Corner or bound for the current step, and the edge endpoints.
	always_comb begin
		px = (k_q[1:0] == 2'd0 || k_q[1:0] == 2'd3) ? e_q.left : e_q.right;
		py = (k_q[1:0] <= 2'd1) ? e_q.top : e_q.bottom;
		if (state_q == B_CLOSE) begin
			xi = C_W'(first_x_q);
			yi = C_W'(first_y_q);
		end else begin
			xi = C_W'(e_q.wx);
			yi = C_W'(e_q.wy);
		end
		xj = C_W'(prev_x_q);
		yj = C_W'(prev_y_q);
		straddle = (yi > py) != (yj > py);
		d   = yj - yi;
		dxp = OP_W'(px) - OP_W'(xi);
		dyp = OP_W'(py) - OP_W'(yi);
		dxj = OP_W'(xj) - OP_W'(xi);
		case (k_q[1:0])
			2'd0:    bound = OP_W'(e_q.left);
			2'd1:    bound = OP_W'(e_q.right);
			2'd2:    bound = OP_W'(e_q.top);
			default: bound = OP_W'(e_q.bottom);
		endcase
		n_op = OP_W'({1'b0, cnt_q});
		if (state_q == B_CENT) begin
			p_lhs  = '0;
			p_rhs  = bound * n_op;
			lhs_nx = k_q[1] ? PROD_W'(sum_y_q) : PROD_W'(sum_x_q);
			mode_nx = k_q[0] ? CMP_LE : CMP_GE;
		end else begin
			p_lhs  = dxp * OP_W'(d);
			p_rhs  = dxj * dyp;
			lhs_nx = p_lhs;
			if (!straddle) begin
				mode_nx = CMP_NONE;
			end else if (d > 0) begin
				mode_nx = CMP_CROSS_POS;
			end else begin
				mode_nx = CMP_CROSS_NEG;
			end
		end
	end

	// Multiply stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_s1 <= CMP_NONE;
		end else begin
			mode_s1 <= issue ? mode_nx : CMP_NONE;
		end
	end

	always_ff @(posedge clk) begin
		lhs_s1 <= lhs_nx;
		rhs_s1 <= p_rhs;
		k_s1   <= k_q[1:0];
	end

	// Control, polygon state and compare stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			k_q         <= '0;
			e_q         <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			cnt_q       <= '0;
			parity_q    <= '0;
			inbox_q     <= 1'b0;
			out_valid_q <= 1'b0;
			collides_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (step_end) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
			if (pop) begin
				e_q <= head;
				// First vertex needs no edge test.
				if (head.add && head.first) begin
					first_x_q <= head.wx;
					first_y_q <= head.wy;
					prev_x_q  <= head.wx;
					prev_y_q  <= head.wy;
					sum_x_q   <= SUM_W'(head.wx);
					sum_y_q   <= SUM_W'(head.wy);
					cnt_q     <= CNT_W'(1);
				end
			end
			// Vertex joins the polygon after its edge is tested.
			if (state_q == B_EDGE && step_end) begin
				prev_x_q <= e_q.wx;
				prev_y_q <= e_q.wy;
				sum_x_q  <= sum_x_q + SUM_W'(e_q.wx);
				sum_y_q  <= sum_y_q + SUM_W'(e_q.wy);
				cnt_q    <= cnt_q + 1'b1;
			end
			if (state_q == B_CLOSE && step_end) begin
				inbox_q <= 1'b1;
			end
			// Compare stage.
			case (mode_s1)
				CMP_CROSS_POS: if (lhs_s1 < rhs_s1) parity_q[k_s1] <= !parity_q[k_s1];
				CMP_CROSS_NEG: if (lhs_s1 > rhs_s1) parity_q[k_s1] <= !parity_q[k_s1];
				CMP_GE:        if (lhs_s1 < rhs_s1) inbox_q <= 1'b0;
				CMP_LE:        if (lhs_s1 > rhs_s1) inbox_q <= 1'b0;
				default:       ;
			endcase
			// Result word and polygon clear.
			if (emit) begin
				out_valid_q <= 1'b1;
				collides_q  <= (|parity_q) || inbox_q;
				prev_x_q    <= '0;
				prev_y_q    <= '0;
				first_x_q   <= '0;
				first_y_q   <= '0;
				sum_x_q     <= '0;
				sum_y_q     <= '0;
				cnt_q       <= '0;
				parity_q    <= '0;
				inbox_q     <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/pro_checker.sv
// Port-level checker for polygon_rect_overlap, bound to the top level.
// Depends on polygon_rect_overlap_macros.svh.
`include "polygon_rect_overlap_macros.svh"

module pro_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic collides
);

	// A stalled result word stays offered and unchanged.
	`PRO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped")
	`PRO_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(collides), "result changed")
	// Results never come back to back.
	`PRO_ASSERT_NEXT(a_out_gap, out_valid && !out_stall, !out_valid, "result repeated")
	// Output flag is never unknown while offered.
	`PRO_ASSERT_NOW(a_out_known, out_valid, !$isunknown(collides), "result unknown")

endmodule

bind polygon_rect_overlap pro_checker u_pro_checker (.*);
